// ===== sv/rvss_pkg.sv =====
// Shared types, constants and segment font for the ratio voltmeter display scanner.
`timescale 1ns / 1ps

package rvss_pkg;

  localparam int unsigned NUM_DIGITS  = 4;
  localparam int unsigned DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int unsigned SAMPLE_W    = 10;
  localparam int unsigned SCALE_W     = 10;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned VALUE_W     = 10;
  localparam int unsigned SEG_W       = 8;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned PROD_W      = SAMPLE_W + SCALE_W;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = PERIOD_W;
  localparam int unsigned BCD_W       = 4;

  localparam logic [VALUE_W-1:0]     VALUE_MAX        = VALUE_W'(999);
  localparam logic [SEG_W-1:0]       SEG_OFF          = 8'hFF;
  localparam logic [DIGIT_IDX_W-1:0] POINT_DIGIT      = DIGIT_IDX_W'(1);
  localparam logic [SCALE_W-1:0]     FULL_SCALE_RST   = SCALE_W'(50);
  localparam logic [PERIOD_W-1:0]    BLINK_PERIOD_RST = PERIOD_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_SCAN   = 2'd1,
    OP_BLINK  = 2'd2,
    OP_BUTTON = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_SCALE   = 1'b0,
    CFG_BLINK_PERIOD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    logic [SAMPLE_W-1:0] vin_sample;
    logic [SAMPLE_W-1:0] vref_sample;
  } in_t;

  typedef struct packed {
    logic [SEG_W-1:0]      segments;
    logic [NUM_DIGITS-1:0] digit_enables;
    logic [VALUE_W-1:0]    shown_value;
  } out_t;

  function automatic logic [SEG_W-1:0] seg_font(input logic [BCD_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_OFF;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/rvss_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transfer.
`timescale 1ns / 1ps

interface rvss_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/ratio_voltmeter_seven_segment_scan.sv =====
// Ratio voltmeter with multiplexed four-digit seven-segment scan driver.
// Flow: a sample item passes the one-bit-per-cycle restoring divider, then the
// clamp, hundreds, low, tens/units and done states; any other item goes to done.
// Throughput: one item at a time; done holds while the output is stalled.
// A finished result waits in the output register while the next item is taken.
// Reset: asynchronous, active low; display off, blink on, all digits and value zero.
`timescale 1ns / 1ps

module ratio_voltmeter_seven_segment_scan (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rvss_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [rvss_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  rvss_stream_if.sink                           in_i,
  rvss_stream_if.source                         out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CLAMP,
    S_HUND,
    S_LOW,
    S_TENS,
    S_DONE
  } state_e;

  localparam int unsigned CNT_W = $clog2(rvss_pkg::PROD_W);

  state_e                               state_q;
  logic [rvss_pkg::SCALE_W-1:0]         full_scale_q;
  logic [rvss_pkg::PERIOD_W-1:0]        blink_period_q;
  logic [rvss_pkg::DIGIT_IDX_W-1:0]     scan_index_q;
  logic [rvss_pkg::BCD_W-1:0]           hund_q;
  logic [rvss_pkg::BCD_W-1:0]           tens_q;
  logic [rvss_pkg::BCD_W-1:0]           units_q;
  logic [6:0]                           low_q;
  logic                                 clear_on_q;
  logic                                 blink_on_q;
  logic [rvss_pkg::PERIOD_W-1:0]        blink_count_q;
  logic [rvss_pkg::VALUE_W-1:0]         last_value_q;
  logic [rvss_pkg::SEG_W-1:0]           seg_drive_q;
  logic [rvss_pkg::NUM_DIGITS-1:0]      enable_drive_q;
  logic [rvss_pkg::PROD_W-1:0]          quo_q;
  logic [rvss_pkg::SAMPLE_W-1:0]        rem_q;
  logic [rvss_pkg::SAMPLE_W-1:0]        vref_q;
  logic [CNT_W-1:0]                     cnt_q;
  logic                                 out_valid_q;
  rvss_pkg::out_t                       out_q;

  logic [rvss_pkg::SAMPLE_W:0]          div_shift;
  logic [rvss_pkg::SAMPLE_W+1:0]        div_diff;
  logic                                 div_ge;
  logic [rvss_pkg::PERIOD_W-1:0]        blink_next;
  logic [rvss_pkg::BCD_W-1:0]           scan_digit;
  logic [rvss_pkg::SEG_W-1:0]           scan_seg;
  logic [15:0]                          hund_prod;
  logic [9:0]                           low_full;
  logic [13:0]                          tens_prod;
  logic [rvss_pkg::BCD_W-1:0]           tens_calc;
  logic [6:0]                           units_full;
  logic                                 in_xfer;

  assign in_i.ready    = (state_q == S_IDLE);
  assign in_xfer       = in_i.valid && in_i.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  assign div_shift = {rem_q, quo_q[rvss_pkg::PROD_W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, vref_q};
  assign div_ge    = !div_diff[rvss_pkg::SAMPLE_W+1];

  assign blink_next = blink_count_q + rvss_pkg::PERIOD_W'(1);

  assign hund_prod  = 16'(last_value_q) * 16'd41;
  assign low_full   = last_value_q - 10'(hund_q) * 10'd100;
  assign tens_prod  = 14'(low_q) * 14'd103;
  assign tens_calc  = tens_prod[13:10];
  assign units_full = low_q - 7'(tens_calc) * 7'd10;

  always_comb begin
    scan_digit = '0;
    if (!clear_on_q) begin
      case (scan_index_q)
        2'd0:    scan_digit = hund_q;
        2'd1:    scan_digit = tens_q;
        2'd2:    scan_digit = units_q;
        default: scan_digit = '0;
      endcase
    end
    scan_seg = rvss_pkg::seg_font(scan_digit);
    if (scan_index_q == rvss_pkg::POINT_DIGIT) begin
      scan_seg[rvss_pkg::SEG_W-1] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= rvss_pkg::FULL_SCALE_RST;
      blink_period_q <= rvss_pkg::BLINK_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (rvss_pkg::cfg_idx_e'(cfg_index_i))
        rvss_pkg::CFG_FULL_SCALE:   full_scale_q <= cfg_data_i[rvss_pkg::SCALE_W-1:0];
        rvss_pkg::CFG_BLINK_PERIOD: blink_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      scan_index_q   <= '0;
      hund_q         <= '0;
      tens_q         <= '0;
      units_q        <= '0;
      low_q          <= '0;
      clear_on_q     <= 1'b0;
      blink_on_q     <= 1'b1;
      blink_count_q  <= '0;
      last_value_q   <= '0;
      seg_drive_q    <= rvss_pkg::SEG_OFF;
      enable_drive_q <= '0;
      quo_q          <= '0;
      rem_q          <= '0;
      vref_q         <= '0;
      cnt_q          <= '0;
      out_valid_q    <= 1'b0;
      out_q          <= '0;
    end else begin
      if (out_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_DONE;
            case (rvss_pkg::op_e'(in_i.payload.opcode))
              rvss_pkg::OP_SAMPLE: begin
                quo_q   <= rvss_pkg::PROD_W'(in_i.payload.vin_sample) *
                           rvss_pkg::PROD_W'(full_scale_q);
                rem_q   <= '0;
                vref_q  <= in_i.payload.vref_sample;
                cnt_q   <= '0;
                state_q <= S_DIV;
              end
              rvss_pkg::OP_SCAN: begin
                if (clear_on_q && !blink_on_q) begin
                  seg_drive_q    <= rvss_pkg::SEG_OFF;
                  enable_drive_q <= '0;
                end else begin
                  seg_drive_q    <= scan_seg;
                  enable_drive_q <= rvss_pkg::NUM_DIGITS'(1) << scan_index_q;
                end
                scan_index_q <= scan_index_q + rvss_pkg::DIGIT_IDX_W'(1);
              end
              rvss_pkg::OP_BLINK: begin
                if (blink_next >= blink_period_q) begin
                  blink_count_q <= '0;
                  blink_on_q    <= clear_on_q ? !blink_on_q : 1'b1;
                end else begin
                  blink_count_q <= blink_next;
                end
              end
              rvss_pkg::OP_BUTTON: begin
                clear_on_q    <= !clear_on_q;
                blink_on_q    <= 1'b1;
                blink_count_q <= '0;
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          rem_q <= div_ge ? div_diff[rvss_pkg::SAMPLE_W-1:0]
                          : div_shift[rvss_pkg::SAMPLE_W-1:0];
          quo_q <= {quo_q[rvss_pkg::PROD_W-2:0], div_ge};
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(rvss_pkg::PROD_W - 1)) begin
            state_q <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          if (vref_q == '0) begin
            last_value_q <= '0;
          end else if (quo_q > rvss_pkg::PROD_W'(rvss_pkg::VALUE_MAX)) begin
            last_value_q <= rvss_pkg::VALUE_MAX;
          end else begin
            last_value_q <= quo_q[rvss_pkg::VALUE_W-1:0];
          end
          state_q <= S_HUND;
        end
        S_HUND: begin
          hund_q  <= hund_prod[15:12];
          state_q <= S_LOW;
        end
        S_LOW: begin
          low_q   <= low_full[6:0];
          state_q <= S_TENS;
        end
        S_TENS: begin
          tens_q  <= tens_calc;
          units_q <= units_full[rvss_pkg::BCD_W-1:0];
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_q.segments      <= seg_drive_q;
            out_q.digit_enables <= enable_drive_q;
            out_q.shown_value   <= last_value_q;
            out_valid_q         <= 1'b1;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
